/* rtl/core/blc_pkg.sv */
// Shared types, register codes, phase codes and reset values for the barrier lane controller.
package blc_pkg;

    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int COUNT_W       = 16;
    localparam int PHASE_W       = 4;
    localparam int TIMER_W_DEF   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IS_ENTRY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT       = 3'd5;

    localparam logic [CFG_W-1:0] RST_WAIT         = 16'd20;
    localparam logic [CFG_W-1:0] RST_TRAVEL       = 16'd100;
    localparam logic [CFG_W-1:0] RST_HOLD         = 16'd500;
    localparam logic [CFG_W-1:0] RST_PASS_TIMEOUT = 16'd2000;
    localparam logic [CFG_W-1:0] RST_REJECT       = 16'd200;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_AUTH    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_REJECT  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_OPENING = 4'd4;
    localparam logic [PHASE_W-1:0] PH_OPEN    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PASSING = 4'd6;
    localparam logic [PHASE_W-1:0] PH_CLOSING = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TIMEOUT = 4'd8;

    typedef struct packed {
        logic loop_active;
        logic entry_allowed;
    } t_in;

    typedef struct packed {
        logic [PHASE_W-1:0] lane_state;
        logic               open_pulse;
        logic               close_pulse;
        logic               buzzer_level;
        logic               beep_burst_pulse;
        logic               authorised_pulse;
        logic               fault;
        logic [COUNT_W-1:0] pass_count;
    } t_out;

    typedef struct packed {
        logic             is_entry_lane;
        logic [CFG_W-1:0] wait_ticks;
        logic [CFG_W-1:0] travel_ticks;
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] pass_max_ticks;
        logic [CFG_W-1:0] buzz_ticks;
    } t_cfg;

endpackage

/* rtl/core/blc_cfg.sv */
// Configuration register file holding the lane type and the phase lengths.
module blc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [blc_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [blc_pkg::CFG_W-1:0]     i_wr_data,
    output blc_pkg::t_cfg                 o_cfg
);
    import blc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_idx)
                REG_IS_ENTRY:     n_cfg.is_entry_lane  = i_wr_data[0];
                REG_WAIT:         n_cfg.wait_ticks     = i_wr_data;
                REG_TRAVEL:       n_cfg.travel_ticks   = i_wr_data;
                REG_HOLD:         n_cfg.hold_ticks     = i_wr_data;
                REG_PASS_TIMEOUT: n_cfg.pass_max_ticks = i_wr_data;
                REG_REJECT:       n_cfg.buzz_ticks     = i_wr_data;
                default:          n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_entry_lane  <= 1'b1;
            r_cfg.wait_ticks     <= RST_WAIT;
            r_cfg.travel_ticks   <= RST_TRAVEL;
            r_cfg.hold_ticks     <= RST_HOLD;
            r_cfg.pass_max_ticks <= RST_PASS_TIMEOUT;
            r_cfg.buzz_ticks     <= RST_REJECT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/blc_step.sv */
// Lane sequencer: phase, timer, pass counter and flags, advanced once per tick.
module blc_step #(
    parameter int TIMER_WIDTH = blc_pkg::TIMER_W_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  blc_pkg::t_in  i_item,
    input  blc_pkg::t_cfg i_cfg,
    output blc_pkg::t_out o_result
);
    import blc_pkg::*;

    localparam int LOAD_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    logic [PHASE_W-1:0]     r_phase;
    logic [PHASE_W-1:0]     n_phase;
    logic [TIMER_WIDTH-1:0] r_ticks;
    logic [TIMER_WIDTH-1:0] n_ticks;
    logic [COUNT_W-1:0]     r_passes;
    logic [COUNT_W-1:0]     n_passes;
    logic                   r_fault;
    logic                   n_fault;
    logic                   r_buzzer;
    logic                   n_buzzer;
    logic [TIMER_WIDTH-1:0] ticks_dec;
    logic                   expired;
    logic                   open_p;
    logic                   close_p;
    logic                   beep_p;
    logic                   auth_p;

    // A zero length runs for one tick; a length above the timer range saturates.
    function automatic logic [TIMER_WIDTH-1:0] f_load(input logic [CFG_W-1:0] v);
        logic [LOAD_W-1:0] ext;
        logic [LOAD_W-1:0] lim;
        ext = LOAD_W'(v);
        lim = LOAD_W'({TIMER_WIDTH{1'b1}});
        if (ext == '0) begin
            ext = LOAD_W'(1);
        end
        if (ext > lim) begin
            ext = lim;
        end
        return TIMER_WIDTH'(ext);
    endfunction

    assign ticks_dec = r_ticks - TIMER_WIDTH'(1);
    assign expired   = (ticks_dec == '0);

    always_comb begin
        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_passes = r_passes;
        n_fault  = r_fault;
        n_buzzer = r_buzzer;
        open_p   = 1'b0;
        close_p  = 1'b0;
        beep_p   = 1'b0;
        auth_p   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.loop_active) begin
                    n_ticks = f_load(i_cfg.wait_ticks);
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!i_item.loop_active) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_ticks = ticks_dec;
                    if (expired) begin
                        n_phase = PH_AUTH;
                    end
                end
            end
            PH_AUTH: begin
                if (i_cfg.is_entry_lane && !i_item.entry_allowed) begin
                    n_buzzer = 1'b1;
                    n_ticks  = f_load(i_cfg.buzz_ticks);
                    n_phase  = PH_REJECT;
                end else begin
                    auth_p  = 1'b1;
                    open_p  = 1'b1;
                    n_ticks = f_load(i_cfg.travel_ticks);
                    n_phase = PH_OPENING;
                end
            end
            PH_REJECT: begin
                n_ticks = ticks_dec;
                if (expired) begin
                    n_buzzer = 1'b0;
                    n_phase  = PH_IDLE;
                end
            end
            PH_OPENING: begin
                n_ticks = ticks_dec;
                if (expired) begin
                    n_ticks = f_load(i_cfg.hold_ticks);
                    n_phase = PH_OPEN;
                end
            end
            PH_OPEN: begin
                if (i_item.loop_active) begin
                    n_ticks = f_load(i_cfg.pass_max_ticks);
                    n_phase = PH_PASSING;
                end else begin
                    n_ticks = ticks_dec;
                    if (expired) begin
                        close_p = 1'b1;
                        n_ticks = f_load(i_cfg.travel_ticks);
                        n_phase = PH_CLOSING;
                    end
                end
            end
            PH_PASSING: begin
                if (!i_item.loop_active) begin
                    n_passes = r_passes + COUNT_W'(1);
                    close_p  = 1'b1;
                    n_ticks  = f_load(i_cfg.travel_ticks);
                    n_phase  = PH_CLOSING;
                end else begin
                    n_ticks = ticks_dec;
                    if (expired) begin
                        n_fault = 1'b1;
                        close_p = 1'b1;
                        beep_p  = 1'b1;
                        n_phase = PH_TIMEOUT;
                    end
                end
            end
            PH_CLOSING: begin
                n_ticks = ticks_dec;
                if (expired) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_TIMEOUT: begin
                if (!i_item.loop_active) begin
                    n_fault = 1'b0;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ticks  <= '0;
            r_passes <= '0;
            r_fault  <= 1'b0;
            r_buzzer <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_ticks  <= n_ticks;
            r_passes <= n_passes;
            r_fault  <= n_fault;
            r_buzzer <= n_buzzer;
        end
    end

    always_comb begin
        o_result.lane_state       = n_phase;
        o_result.open_pulse       = open_p;
        o_result.close_pulse      = close_p;
        o_result.buzzer_level     = n_buzzer;
        o_result.beep_burst_pulse = beep_p;
        o_result.authorised_pulse = auth_p;
        o_result.fault            = n_fault;
        o_result.pass_count       = n_passes;
    end

endmodule

/* rtl/core/barrier_lane_controller.sv */
// Top level of the barrier lane controller: tick input, result register and configuration port.
//
// Each input transfer on i_in_* is one tick of the lane sequencer, carrying the loop level
// and the lot-has-room flag. Each tick produces exactly one result transfer on o_out_*,
// giving the phase after the tick, the command pulses, buzzer and fault levels and the
// wrapping count of vehicles that passed.
// The result of a tick is registered and is valid in the cycle after it is accepted.
// Throughput is one tick per cycle while results are taken; the sequencer state and the result
// register are both updated in the accepting cycle, so the next tick may follow right away.
// o_in_ready is high while the result register is empty or is being emptied in the
// same cycle. When the receiver stalls, the result is held and one more tick is not
// taken until it drains.
// Configuration writes are registered through i_cfg_wr_en, i_cfg_idx and
// i_cfg_wr_data; writes to indexes beyond the register list are ignored.
// Synchronous reset puts the lane in idle with a zero pass count, clears the fault and
// buzzer, restores the default lengths and empties the result register. No pulse is
// produced by reset.
module barrier_lane_controller #(
    parameter int TIMER_WIDTH = blc_pkg::TIMER_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  blc_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output blc_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [blc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [blc_pkg::CFG_W-1:0]     i_cfg_wr_data
);
    import blc_pkg::*;

    t_cfg cfg;
    t_out result;
    logic in_xfer;
    logic r_out_valid;
    logic n_out_valid;
    t_out r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    blc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_idx     (i_cfg_idx),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (cfg)
    );

    blc_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_xfer),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_xfer) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/blc_checker.sv */
// Port-level checks for the barrier lane controller, bound to the top level.
module blc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input blc_pkg::t_out o_out_data
);
    import blc_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted tick produced no result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_open_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.open_pulse) |->
        (o_out_data.lane_state == PH_OPENING && o_out_data.authorised_pulse))
        else $error("open pulse outside opening phase");

    a_close_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.close_pulse) |->
        (o_out_data.lane_state == PH_CLOSING || o_out_data.lane_state == PH_TIMEOUT))
        else $error("close pulse outside closing or timeout");

    a_beep_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.beep_burst_pulse) |->
        (o_out_data.fault && o_out_data.lane_state == PH_TIMEOUT))
        else $error("beep burst without timeout fault");

endmodule

bind barrier_lane_controller blc_checker u_blc_checker (.*);
